// ===== src/hlsd_pkg.sv =====
// Shared types and constants of the hourly LED schedule dimmer.
`timescale 1ns / 1ps
`default_nettype none

package hlsd_pkg;

    localparam int FUNC_W  = 3;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int CHAN_W  = 3;
    localparam int FIELD_W = 8;
    localparam int FIELDS  = 7;

    localparam int MINUTES_PER_HOUR = 60;

    typedef logic [FIELDS-1:0][FIELD_W-1:0] t_field_vec;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK       = 3'd0,
        FN_WRITE_SLOT = 3'd1,
        FN_SET_ALL    = 3'd2,
        FN_SET_ONE    = 3'd3,
        FN_MANUAL     = 3'd4,
        FN_OFF        = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_NEXT,
        S_MUL,
        S_DIV,
        S_PUB
    } t_state;

    typedef enum logic [2:0] {
        DRV_NONE,
        DRV_SET_ALL,
        DRV_SET_ONE,
        DRV_ZERO,
        DRV_RECALL
    } t_drv_op;

    typedef struct packed {
        logic    capture_time;
        logic    rd_next;
        logic    mul;
        logic    div;
        logic    div_store;
        logic    wr_slot;
        t_drv_op drv_op;
        logic    store_en;
        logic    store_fill;
        logic    publish;
    } t_dp_cmd;

    typedef struct packed {
        logic hour_ok;
        logic chan_ok;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/hourly_led_schedule_dimmer_core.sv =====
// Top level of the hourly LED schedule dimmer: controller plus datapath.
// Sequence: a set, recall or off beat updates the drive register, then the result register
//   takes it in the publish step; a tick or a manual toggle that needs the profile runs
//   two reads of the schedule memory, a multiply stage and a reciprocal-divide stage first.
// Throughput: one beat every cycle for writes and beats with no result; sets, recalls, off
//   beats and profile beats hold the input side busy until their result is published, and
//   a stalled result holds the publish step.
// Reset: synchronous, active low; clears the schedule row-valid bits, drive levels, mode
//   flags and the result valid, so every slot reads as zero until written.
`timescale 1ns / 1ps
`default_nettype none

module hourly_led_schedule_dimmer_core #(
    parameter int SLOTS      = 24,
    parameter int CHANNELS   = 7,
    parameter int LEVEL_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input beat
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_func,
    input  wire logic [4:0] i_hour,
    input  wire logic [5:0] i_minute,
    input  wire logic [2:0] i_channel_index,
    input  wire logic       i_flag,
    input  wire logic [7:0] i_ch0_level,
    input  wire logic [7:0] i_ch1_level,
    input  wire logic [7:0] i_ch2_level,
    input  wire logic [7:0] i_ch3_level,
    input  wire logic [7:0] i_ch4_level,
    input  wire logic [7:0] i_ch5_level,
    input  wire logic [7:0] i_ch6_level,
    // result beat
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_drive_ch0,
    output logic [7:0]      o_drive_ch1,
    output logic [7:0]      o_drive_ch2,
    output logic [7:0]      o_drive_ch3,
    output logic [7:0]      o_drive_ch4,
    output logic [7:0]      o_drive_ch5,
    output logic [7:0]      o_drive_ch6
);
    import hlsd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_stat   stat;
    t_field_vec levels;
    t_field_vec drive;

    // Gather the seven level fields into one vector; channel 0 doubles as the
    // value of a single-channel set.
    assign levels[0] = i_ch0_level;
    assign levels[1] = i_ch1_level;
    assign levels[2] = i_ch2_level;
    assign levels[3] = i_ch3_level;
    assign levels[4] = i_ch4_level;
    assign levels[5] = i_ch5_level;
    assign levels[6] = i_ch6_level;

    // The controller owns the mode flags (manual, off, store saved) and decides
    // per beat which datapath operation runs; it takes a beat only in idle.
    hlsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_func  (i_func),
        .i_flag  (i_flag),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath holds the schedule memory, the two-stage interpolation lanes,
    // the drive and manual-store registers and the result register that parts
    // the result side from the input side.
    hlsd_datapath #(
        .SLOTS      (SLOTS),
        .CHANNELS   (CHANNELS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_channel_index (i_channel_index),
        .i_levels        (levels),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive         (drive)
    );

    assign o_drive_ch0 = drive[0];
    assign o_drive_ch1 = drive[1];
    assign o_drive_ch2 = drive[2];
    assign o_drive_ch3 = drive[3];
    assign o_drive_ch4 = drive[4];
    assign o_drive_ch5 = drive[5];
    assign o_drive_ch6 = drive[6];

endmodule

`default_nettype wire

// ===== src/hlsd_ctrl.sv =====
// Controller state machine: mode flags, item decode and datapath sequencing.
`timescale 1ns / 1ps
`default_nettype none

module hlsd_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [hlsd_pkg::FUNC_W-1:0] i_func,
    input  wire logic                      i_flag,
    input  wire hlsd_pkg::t_dp_stat        i_stat,
    output hlsd_pkg::t_dp_cmd              o_cmd
);
    import hlsd_pkg::*;

    t_state r_state, n_state;
    logic   r_manual_on, n_manual_on;
    logic   r_off_on, n_off_on;
    logic   r_saved, n_saved;
    logic   r_fill_store, n_fill_store;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_manual_on  <= 1'b0;
            r_off_on     <= 1'b0;
            r_saved      <= 1'b0;
            r_fill_store <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_manual_on  <= n_manual_on;
            r_off_on     <= n_off_on;
            r_saved      <= n_saved;
            r_fill_store <= n_fill_store;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_manual_on  = r_manual_on;
        n_off_on     = r_off_on;
        n_saved      = r_saved;
        n_fill_store = r_fill_store;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_func'(i_func))
                        FN_TICK: begin
                            if (!r_off_on && !r_manual_on) begin
                                o_cmd.capture_time = 1'b1;
                                n_fill_store       = 1'b0;
                                n_state            = S_RD_NEXT;
                            end
                        end
                        FN_WRITE_SLOT: begin
                            o_cmd.wr_slot = i_stat.hour_ok;
                        end
                        FN_SET_ALL: begin
                            o_cmd.drv_op     = DRV_SET_ALL;
                            o_cmd.store_en   = r_manual_on;
                            o_cmd.store_fill = !r_saved;
                            n_saved          = r_saved || r_manual_on;
                            n_state          = S_PUB;
                        end
                        FN_SET_ONE: begin
                            if (i_stat.chan_ok) begin
                                o_cmd.drv_op     = DRV_SET_ONE;
                                o_cmd.store_en   = r_manual_on;
                                o_cmd.store_fill = !r_saved;
                                n_saved          = r_saved || r_manual_on;
                                n_state          = S_PUB;
                            end
                        end
                        FN_MANUAL: begin
                            if (!r_manual_on && i_flag) begin
                                if (r_saved) begin
                                    o_cmd.drv_op = DRV_RECALL;
                                    n_state      = S_PUB;
                                end else begin
                                    // fill the store with the profile on the way
                                    o_cmd.capture_time = 1'b1;
                                    n_fill_store       = 1'b1;
                                    n_saved            = 1'b1;
                                    n_state            = S_RD_NEXT;
                                end
                            end else if (r_manual_on && !i_flag) begin
                                o_cmd.capture_time = 1'b1;
                                n_fill_store       = 1'b0;
                                n_state            = S_RD_NEXT;
                            end
                            n_manual_on = i_flag;
                        end
                        FN_OFF: begin
                            n_off_on = i_flag;
                            if (i_flag) begin
                                o_cmd.drv_op     = DRV_ZERO;
                                o_cmd.store_en   = r_manual_on;
                                o_cmd.store_fill = !r_saved;
                                n_saved          = r_saved || r_manual_on;
                                n_manual_on      = 1'b1;
                                n_state          = S_PUB;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_NEXT: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div       = 1'b1;
                o_cmd.div_store = r_fill_store;
                n_state         = S_PUB;
            end
            S_PUB: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/hlsd_datapath.sv =====
// Datapath: schedule memory, interpolation lanes, drive and manual store, result register.
`timescale 1ns / 1ps
`default_nettype none

module hlsd_datapath #(
    parameter int SLOTS      = 24,
    parameter int CHANNELS   = 7,
    parameter int LEVEL_BITS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire hlsd_pkg::t_dp_cmd           i_cmd,
    output hlsd_pkg::t_dp_stat               o_stat,
    input  wire logic [hlsd_pkg::HOUR_W-1:0] i_hour,
    input  wire logic [hlsd_pkg::MIN_W-1:0]  i_minute,
    input  wire logic [hlsd_pkg::CHAN_W-1:0] i_channel_index,
    input  wire hlsd_pkg::t_field_vec        i_levels,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output hlsd_pkg::t_field_vec             o_drive
);
    import hlsd_pkg::*;

    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int HOUR_SPAN   = 1 << HOUR_W;
    localparam int NUM_W       = LEVEL_BITS + MIN_W;
    localparam int RECIP_SHIFT = NUM_W + MIN_W;
    localparam int RECIP_W     = NUM_W + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam longint unsigned RecipFull =
        ((64'd1 << RECIP_SHIFT) + MINUTES_PER_HOUR - 1) / MINUTES_PER_HOUR;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RecipFull);

    typedef logic [CHANNELS-1:0][LEVEL_BITS-1:0] t_row;
    typedef logic [HOUR_SPAN-1:0][SLOT_W-1:0]    t_slot_lut;

    function automatic t_slot_lut f_slot_lut();
        t_slot_lut lut;
        for (int h = 0; h < HOUR_SPAN; h++) begin
            lut[h] = SLOT_W'(h % SLOTS);
        end
        return lut;
    endfunction

    localparam t_slot_lut SlotLut = f_slot_lut();

    t_row                     r_mem [SLOTS];
    logic [SLOTS-1:0]         r_row_valid;
    t_row                     r_rdata;
    logic                     r_rd_valid;
    logic [SLOT_W-1:0]        raddr;
    logic [SLOT_W-1:0]        waddr;
    logic [SLOT_W-1:0]        next_slot;

    logic [SLOT_W-1:0]        r_slot;
    logic [MIN_W-1:0]         r_min;
    logic [MIN_W-1:0]         min_rest;
    t_row                     r_cur_row;
    t_row                     nxt_row;
    logic [CHANNELS-1:0][NUM_W-1:0] r_num, n_num;
    t_row                     quot;

    t_row                     in_lvl;
    t_row                     r_drive, n_drive;
    t_row                     r_store, n_store;
    logic [CHANNELS-1:0]      chg;
    logic [LEVEL_BITS-1:0]    one_lvl;

    t_field_vec               r_out;
    t_field_vec               out_next;
    logic                     r_out_valid;

    // status back to the controller
    assign o_stat.hour_ok  = (32'(i_hour) < 32'(SLOTS));
    assign o_stat.chan_ok  = (32'(i_channel_index) < 32'(CHANNELS));
    assign o_stat.out_free = !r_out_valid || !i_stall;

    // ---------------- schedule memory ----------------
    assign waddr     = SLOT_W'(i_hour);
    assign next_slot = (r_slot == SLOT_W'(SLOTS - 1)) ? '0 : r_slot + 1'b1;
    assign raddr     = i_cmd.rd_next ? next_slot : SlotLut[i_hour];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_slot) begin
            r_mem[waddr] <= in_lvl;
        end
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.wr_slot) begin
            r_row_valid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_row_valid[raddr];
    end

    // ---------------- interpolation ----------------
    assign nxt_row  = r_rd_valid ? r_rdata : '0;
    assign min_rest = MIN_W'(MINUTES_PER_HOUR) - r_min;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_time) begin
            r_slot <= SlotLut[i_hour];
            r_min  <= (i_minute > MIN_W'(MINUTES_PER_HOUR)) ?
                      MIN_W'(MINUTES_PER_HOUR) : i_minute;
        end
        if (i_cmd.rd_next) begin
            r_cur_row <= nxt_row;
        end
        if (i_cmd.mul) begin
            r_num <= n_num;
        end
    end

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_lane
            logic [PROD_W-1:0] prod;
            assign n_num[c] = NUM_W'(r_cur_row[c]) * NUM_W'(min_rest)
                            + NUM_W'(nxt_row[c]) * NUM_W'(r_min);
            // exact floor divide by sixty through the reciprocal
            assign prod    = PROD_W'(r_num[c]) * PROD_W'(RECIP);
            assign quot[c] = prod[RECIP_SHIFT +: LEVEL_BITS];
            if (c < FIELDS) begin : g_in
                assign in_lvl[c] = LEVEL_BITS'(i_levels[c]);
            end else begin : g_no_in
                assign in_lvl[c] = '0;
            end
        end
    endgenerate

    // ---------------- drive and manual store ----------------
    assign one_lvl = LEVEL_BITS'(i_levels[0]);

    always_comb begin
        n_drive = r_drive;
        n_store = r_store;
        chg     = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            case (i_cmd.drv_op)
                DRV_SET_ALL: begin
                    chg[k]     = 1'b1;
                    n_drive[k] = in_lvl[k];
                end
                DRV_SET_ONE: begin
                    chg[k] = (i_channel_index == CHAN_W'(k));
                    if (chg[k]) begin
                        n_drive[k] = one_lvl;
                    end
                end
                DRV_ZERO: begin
                    chg[k]     = 1'b1;
                    n_drive[k] = '0;
                end
                DRV_RECALL: begin
                    n_drive[k] = r_store[k];
                end
                default: begin
                    chg[k] = 1'b0;
                end
            endcase
            if (i_cmd.div) begin
                n_drive[k] = quot[k];
            end
            if (i_cmd.store_en && (i_cmd.store_fill || chg[k])) begin
                n_store[k] = n_drive[k];
            end
            if (i_cmd.div && i_cmd.div_store) begin
                n_store[k] = quot[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= '0;
        end else begin
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
    end

    // ---------------- result register ----------------
    genvar f;
    generate
        for (f = 0; f < FIELDS; f++) begin : g_out
            if (f < CHANNELS) begin : g_used
                assign out_next[f] = FIELD_W'(r_drive[f]);
            end else begin : g_unused
                assign out_next[f] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out <= out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_out;

endmodule

`default_nettype wire

// ===== src/hlsd_checker.sv =====
// Port-level checker of the dimmer core and its bind.
`timescale 1ns / 1ps
`default_nettype none

module hlsd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [2:0] i_func,
    input wire logic       i_flag,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_drive_ch0,
    input wire logic [7:0] o_drive_ch1,
    input wire logic [7:0] o_drive_ch2,
    input wire logic [7:0] o_drive_ch3,
    input wire logic [7:0] o_drive_ch4,
    input wire logic [7:0] o_drive_ch5,
    input wire logic [7:0] o_drive_ch6
);
    import hlsd_pkg::*;

    logic in_beat;
    assign in_beat = i_valid && !o_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive_ch0) && $stable(o_drive_ch6))
        else $error("stalled result changed");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a slot write never causes a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_func == FN_WRITE_SLOT) |-> ##2 !$rose(o_valid))
        else $error("slot write produced a result");

    // a set-all beat keeps the block busy for its publish cycle
    a_set_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_func == FN_SET_ALL) |=> o_stall)
        else $error("set-all did not hold the input side");

    // switching off with a free result register shows all channels dark
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_func == FN_OFF) && i_flag && !o_valid |-> ##2
        (o_valid && o_drive_ch0 == 8'd0 && o_drive_ch1 == 8'd0 && o_drive_ch2 == 8'd0
         && o_drive_ch3 == 8'd0 && o_drive_ch4 == 8'd0 && o_drive_ch5 == 8'd0
         && o_drive_ch6 == 8'd0))
        else $error("off beat did not zero the drive");

endmodule

bind hourly_led_schedule_dimmer_core hlsd_checker u_hlsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_func      (i_func),
    .i_flag      (i_flag),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_drive_ch0 (o_drive_ch0),
    .o_drive_ch1 (o_drive_ch1),
    .o_drive_ch2 (o_drive_ch2),
    .o_drive_ch3 (o_drive_ch3),
    .o_drive_ch4 (o_drive_ch4),
    .o_drive_ch5 (o_drive_ch5),
    .o_drive_ch6 (o_drive_ch6)
);

`default_nettype wire

// ===== tb/sv/hourly_led_schedule_dimmer_core_tb.sv =====
// Self-checking testbench of the hourly LED schedule dimmer core.
`timescale 1ns / 1ps

module hourly_led_schedule_dimmer_core_tb;

    import hlsd_pkg::*;

    localparam int SLOTS    = 24;
    localparam int CHANNELS = 7;

    // Function codes the block has no meaning for; it must drop them.
    localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;
    // A channel index one past the last channel.
    localparam logic [CHAN_W-1:0] CHAN_OUT    = 3'd7;

    // One input beat, field for field.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [CHAN_W-1:0] chan;
        logic              flag;
        t_field_vec        lvl;
    } t_beat;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic              i_valid         = 1'b0;
    logic [2:0]        i_func          = '0;
    logic [4:0]        i_hour          = '0;
    logic [5:0]        i_minute        = '0;
    logic [2:0]        i_channel_index = '0;
    logic              i_flag          = 1'b0;
    logic [7:0]        i_ch0_level     = '0;
    logic [7:0]        i_ch1_level     = '0;
    logic [7:0]        i_ch2_level     = '0;
    logic [7:0]        i_ch3_level     = '0;
    logic [7:0]        i_ch4_level     = '0;
    logic [7:0]        i_ch5_level     = '0;
    logic [7:0]        i_ch6_level     = '0;
    logic              i_stall         = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [7:0]        o_drive_ch0;
    logic [7:0]        o_drive_ch1;
    logic [7:0]        o_drive_ch2;
    logic [7:0]        o_drive_ch3;
    logic [7:0]        o_drive_ch4;
    logic [7:0]        o_drive_ch5;
    logic [7:0]        o_drive_ch6;

    // Random idling on both sides; cleared for the steady-stream stretch.
    logic gaps_on = 1'b1;

    // Shadow copy of the block's state.
    logic [7:0] sched [SLOTS][CHANNELS];
    t_field_vec drive_now;
    t_field_vec manual_levels;
    logic       manual_saved;
    logic       shadow_manual;
    logic       shadow_off;

    // Drive levels still to come out of the block, oldest first.
    t_field_vec drive_expected [$];
    int         mismatches = 0;

    hourly_led_schedule_dimmer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_channel_index (i_channel_index),
        .i_flag          (i_flag),
        .i_ch0_level     (i_ch0_level),
        .i_ch1_level     (i_ch1_level),
        .i_ch2_level     (i_ch2_level),
        .i_ch3_level     (i_ch3_level),
        .i_ch4_level     (i_ch4_level),
        .i_ch5_level     (i_ch5_level),
        .i_ch6_level     (i_ch6_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive_ch0     (o_drive_ch0),
        .o_drive_ch1     (o_drive_ch1),
        .o_drive_ch2     (o_drive_ch2),
        .o_drive_ch3     (o_drive_ch3),
        .o_drive_ch4     (o_drive_ch4),
        .o_drive_ch5     (o_drive_ch5),
        .o_drive_ch6     (o_drive_ch6)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake or a result that never shows ends here.
    initial begin : watchdog
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Blend the current hour's profile toward the next one by the minute.
    // The last slot wraps to slot 0; minutes past 60 count as 60.
    function automatic t_field_vec blend_profile(input logic [4:0] hr, input logic [5:0] mn);
        t_field_vec prof;
        int slot;
        int nxt;
        int m;
        int a;
        int b;
        int c;
        slot = int'(hr) % SLOTS;
        nxt  = (slot + 1) % SLOTS;
        m    = (int'(mn) > MINUTES_PER_HOUR) ? MINUTES_PER_HOUR : int'(mn);
        prof = '0;
        for (c = 0; c < CHANNELS; c++) begin
            a = sched[slot][c];
            b = sched[nxt][c];
            prof[c] = 8'((a * (MINUTES_PER_HOUR - m) + b * m) / MINUTES_PER_HOUR);
        end
        return prof;
    endfunction

    // Drive one channel; in manual mode also remember it, filling the
    // manual store from the drive the first time.
    function automatic void put_level(input int c, input logic [7:0] v);
        drive_now[c] = v;
        if (shadow_manual) begin
            if (!manual_saved) begin
                manual_levels = drive_now;
                manual_saved  = 1'b1;
            end
            manual_levels[c] = drive_now[c];
        end
    endfunction

    // Advance the shadow state by one accepted beat and queue the drive
    // levels the block must report, if any.
    function automatic void predict_drive(input t_beat b);
        logic emit;
        int c;
        emit = 1'b0;
        case (b.func)
            FN_TICK: begin
                if (!shadow_off && !shadow_manual) begin
                    drive_now = blend_profile(b.hour, b.minute);
                    emit = 1'b1;
                end
            end
            FN_WRITE_SLOT: begin
                if (b.hour < SLOTS) begin
                    for (c = 0; c < CHANNELS; c++) sched[b.hour][c] = b.lvl[c];
                end
            end
            FN_SET_ALL: begin
                for (c = 0; c < CHANNELS; c++) put_level(c, b.lvl[c]);
                emit = 1'b1;
            end
            FN_SET_ONE: begin
                if (b.chan < CHANNELS) begin
                    put_level(int'(b.chan), b.lvl[0]);
                    emit = 1'b1;
                end
            end
            FN_MANUAL: begin
                if (!shadow_manual && b.flag) begin
                    if (!manual_saved) begin
                        manual_levels = blend_profile(b.hour, b.minute);
                        manual_saved  = 1'b1;
                    end
                    drive_now = manual_levels;
                    emit = 1'b1;
                end else if (shadow_manual && !b.flag) begin
                    drive_now = blend_profile(b.hour, b.minute);
                    emit = 1'b1;
                end
                shadow_manual = b.flag;
            end
            FN_OFF: begin
                shadow_off = b.flag;
                if (b.flag) begin
                    for (c = 0; c < CHANNELS; c++) put_level(c, 8'd0);
                    shadow_manual = 1'b1;
                    emit = 1'b1;
                end
            end
            default: ;
        endcase
        if (emit) drive_expected.push_back(drive_now);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, compare every accepted result beat
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_stall <= gaps_on && ($urandom_range(0, 99) < 32);
    end

    always @(posedge i_clk) begin : check_drive
        t_field_vec got;
        t_field_vec want;
        int c;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_drive_ch6, o_drive_ch5, o_drive_ch4, o_drive_ch3,
                   o_drive_ch2, o_drive_ch1, o_drive_ch0};
            if (drive_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = drive_expected.pop_front();
                for (c = 0; c < CHANNELS; c++) begin
                    if (got[c] !== want[c]) begin
                        $display("%0t: drive_ch%0d expected %0d actual %0d",
                                 $time, c, want[c], got[c]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one beat, hold it until accepted, then predict. Valid stays
    // high on return so back-to-back beats need no second write of valid
    // in one step; anything that lets time pass must go through
    // wait_drained or the gap loop below, both of which lower it.
    task automatic send_beat(input t_beat b);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 32) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid         <= 1'b1;
        i_func          <= b.func;
        i_hour          <= b.hour;
        i_minute        <= b.minute;
        i_channel_index <= b.chan;
        i_flag          <= b.flag;
        i_ch0_level     <= b.lvl[0];
        i_ch1_level     <= b.lvl[1];
        i_ch2_level     <= b.lvl[2];
        i_ch3_level     <= b.lvl[3];
        i_ch4_level     <= b.lvl[4];
        i_ch5_level     <= b.lvl[5];
        i_ch6_level     <= b.lvl[6];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_drive(b);
    endtask

    // Drop valid, wait for every queued result, then let the longest
    // profile beat finish in case the last beat had no result.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (drive_expected.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic t_beat make_beat(input logic [2:0] f, input logic [4:0] hr,
                                        input logic [5:0] mn, input logic [2:0] ch,
                                        input logic fl, input t_field_vec lv);
        t_beat b;
        b.func   = f;
        b.hour   = hr;
        b.minute = mn;
        b.chan   = ch;
        b.flag   = fl;
        b.lvl    = lv;
        return b;
    endfunction

    function automatic t_field_vec rand_levels();
        t_field_vec lv;
        int c;
        for (c = 0; c < FIELDS; c++) begin
            case ($urandom_range(0, 7))
                0:       lv[c] = 8'h00;
                1:       lv[c] = 8'hff;
                default: lv[c] = 8'($urandom_range(0, 255));
            endcase
        end
        return lv;
    endfunction

    // Mostly legal fields with an occasional out-of-range hour, minute
    // or channel; off toggles lean toward clearing so ticks get through.
    function automatic t_beat rand_beat();
        t_beat b;
        int pick;
        pick     = $urandom_range(0, 99);
        b.hour   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                               : 5'($urandom_range(0, 23));
        b.minute = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                               : 6'($urandom_range(0, 59));
        b.chan   = ($urandom_range(0, 9) == 0) ? CHAN_OUT : 3'($urandom_range(0, 6));
        b.flag   = 1'($urandom_range(0, 1));
        b.lvl    = rand_levels();
        if (pick < 34)      b.func = FN_TICK;
        else if (pick < 50) b.func = FN_WRITE_SLOT;
        else if (pick < 60) b.func = FN_SET_ALL;
        else if (pick < 71) b.func = FN_SET_ONE;
        else if (pick < 83) b.func = FN_MANUAL;
        else if (pick < 94) begin
            b.func = FN_OFF;
            b.flag = ($urandom_range(0, 99) < 35);
        end
        else                b.func = $urandom_range(0, 1) ? FN_UNUSED_A : FN_UNUSED_B;
        return b;
    endfunction

    // Back to auto mode, then a run of ticks through consecutive hours.
    task automatic send_day_run(output int sent);
        int hr;
        int k;
        hr = $urandom_range(0, 23);
        send_beat(make_beat(FN_OFF, 5'(hr), '0, '0, 1'b0, rand_levels()));
        send_beat(make_beat(FN_MANUAL, 5'(hr), 6'($urandom_range(0, 59)), '0, 1'b0,
                            rand_levels()));
        for (k = 0; k < 4; k++) begin
            send_beat(make_beat(FN_TICK, 5'((hr + k) % SLOTS), 6'($urandom_range(0, 59)),
                                '0, 1'b0, rand_levels()));
        end
        sent = 6;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The table is cleared at reset, so the first tick drives zero.
    task automatic test_cleared_table();
        send_beat(make_beat(FN_TICK, 5'd23, 6'd59, '0, 1'b0, {7{8'hff}}));
    endtask

    // Slot writes, including ones past the table, and ticks at the edges:
    // last-slot wrap, minute clamp, hour reduced modulo the slot count.
    task automatic test_slot_writes_and_ticks();
        send_beat(make_beat(FN_WRITE_SLOT, 5'd0, '0, '0, 1'b0, {7{8'hff}}));
        send_beat(make_beat(FN_WRITE_SLOT, 5'd23, '0, '0, 1'b0, {7{8'h00}}));
        send_beat(make_beat(FN_WRITE_SLOT, 5'd7, '0, '0, 1'b0,
                            {8'h01, 8'h80, 8'h7f, 8'hfe, 8'h55, 8'haa, 8'h3c}));
        send_beat(make_beat(FN_WRITE_SLOT, 5'd24, '0, '0, 1'b0, {7{8'h99}}));
        send_beat(make_beat(FN_WRITE_SLOT, 5'd31, '0, '0, 1'b0, {7{8'h66}}));
        send_beat(make_beat(FN_TICK, 5'd0, 6'd0, '0, 1'b0, '0));
        send_beat(make_beat(FN_TICK, 5'd0, 6'd59, '0, 1'b0, '0));
        send_beat(make_beat(FN_TICK, 5'd23, 6'd59, '0, 1'b0, '0));
        send_beat(make_beat(FN_TICK, 5'd23, 6'd63, '0, 1'b0, '0));
        send_beat(make_beat(FN_TICK, 5'd24, 6'd10, '0, 1'b0, '0));
        send_beat(make_beat(FN_TICK, 5'd31, 6'd45, '0, 1'b0, '0));
    endtask

    // Direct sets in auto mode; a set on a missing channel is dropped.
    task automatic test_direct_sets();
        send_beat(make_beat(FN_SET_ALL, '0, '0, '0, 1'b0, {7{8'hff}}));
        send_beat(make_beat(FN_SET_ALL, '0, '0, '0, 1'b0,
                            {8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00}));
        send_beat(make_beat(FN_SET_ONE, '0, '0, 3'd6, 1'b0, {7{8'ha5}}));
        send_beat(make_beat(FN_SET_ONE, '0, '0, CHAN_OUT, 1'b0, {7{8'h5a}}));
    endtask

    // First entry to manual takes the profile, re-entry recalls the store,
    // off forces zero and manual, and a tick is blocked meanwhile.
    task automatic test_mode_changes();
        send_beat(make_beat(FN_MANUAL, 5'd0, 6'd20, '0, 1'b1, '0));
        send_beat(make_beat(FN_SET_ONE, '0, '0, 3'd2, 1'b0, {7{8'h42}}));
        send_beat(make_beat(FN_MANUAL, 5'd6, 6'd30, '0, 1'b0, '0));
        send_beat(make_beat(FN_MANUAL, 5'd6, 6'd30, '0, 1'b1, '0));
        send_beat(make_beat(FN_OFF, '0, '0, '0, 1'b1, '0));
        send_beat(make_beat(FN_TICK, 5'd7, 6'd0, '0, 1'b0, '0));
        send_beat(make_beat(FN_OFF, '0, '0, '0, 1'b0, '0));
        send_beat(make_beat(FN_MANUAL, 5'd7, 6'd15, '0, 1'b0, '0));
    endtask

    // Unused function codes are dropped.
    task automatic test_unused_codes();
        send_beat(make_beat(FN_UNUSED_A, 5'd3, 6'd3, 3'd3, 1'b1, {7{8'hff}}));
        send_beat(make_beat(FN_UNUSED_B, 5'd3, 6'd3, 3'd3, 1'b1, {7{8'hff}}));
    endtask

    // Random mix with day runs; halfway through, hold the sender until
    // every result is back.
    task automatic test_random_traffic(input int count);
        int sent;
        int run;
        logic paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < count) begin
            if (!paused && sent >= count / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 8) begin
                send_day_run(run);
                sent += run;
            end else begin
                send_beat(rand_beat());
                sent++;
            end
        end
    endtask

    // Same traffic with neither side idling.
    task automatic test_steady_stream(input int count);
        wait_drained();
        gaps_on <= 1'b0;
        test_random_traffic(count);
        wait_drained();
        gaps_on <= 1'b1;
    endtask

    initial begin : run_all
        int s;
        int c;
        for (s = 0; s < SLOTS; s++)
            for (c = 0; c < CHANNELS; c++) sched[s][c] = 8'd0;
        drive_now     = '0;
        manual_levels = '0;
        manual_saved  = 1'b0;
        shadow_manual = 1'b0;
        shadow_off    = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_table();
        test_slot_writes_and_ticks();
        test_direct_sets();
        test_mode_changes();
        test_unused_codes();
        test_random_traffic(1000);
        test_steady_stream(620);

        wait_drained();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== hourly_led_schedule_dimmer_core.f =====
src/hlsd_pkg.sv
src/hlsd_ctrl.sv
src/hlsd_datapath.sv
src/hourly_led_schedule_dimmer_core.sv
src/hlsd_checker.sv
tb/sv/hourly_led_schedule_dimmer_core_tb.sv
